>>> src/wmt_pkg.sv
`timescale 1ns / 1ps
package wmt_pkg;

  // Field widths of one beat on either channel.
  localparam int KEY_BITS    = 16;
  localparam int WEIGHT_BITS = 32;
  localparam int KIND_BITS   = 2;
  localparam int STATUS_BITS = 2;

  // Operation codes carried in the kind field.
  localparam logic [KIND_BITS-1:0] OP_PUSH = 2'd0;
  localparam logic [KIND_BITS-1:0] OP_POP  = 2'd1;
  localparam logic [KIND_BITS-1:0] OP_TOP  = 2'd2;

  // Status codes of one result beat.
  localparam logic [STATUS_BITS-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_BITS-1:0] ST_EMPTY = 2'd1;
  localparam logic [STATUS_BITS-1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic [KIND_BITS-1:0]          kind;
    logic [KEY_BITS-1:0]           key;
    logic signed [WEIGHT_BITS-1:0] weight;
  } wmt_in_t;

  typedef struct packed {
    logic [KEY_BITS-1:0]    result_key;
    logic [STATUS_BITS-1:0] status;
  } wmt_out_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic start;
    logic read;
    logic commit;
    logic emit;
  } wmt_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic last;
    logic out_free;
  } wmt_sts_t;

endpackage

>>> src/wmt_ram.sv
`timescale 1ns / 1ps
module wmt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // One write port and one registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> src/wmt_ctrl.sv
`timescale 1ns / 1ps
module wmt_ctrl import wmt_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  wmt_sts_t sts_i,
  output wmt_cmd_t cmd_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_DRAIN,
    S_COMMIT,
    S_OUT
  } state_e;

  state_e state_q, state_d;

  // Next state and commands decoded from the current state.
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_stall_o = 1'b1;
    unique case (state_q)
      S_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.start = 1'b1;
          state_d     = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd_o.read = 1'b1;
        if (sts_i.last) begin
          state_d = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_d = S_COMMIT;
      end
      S_COMMIT: begin
        cmd_o.commit = 1'b1;
        state_d      = S_OUT;
      end
      S_OUT: begin
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

>>> src/wmt_dp.sv
`timescale 1ns / 1ps
module wmt_dp import wmt_pkg::*; #(
  parameter int ENTRIES = 64
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  wmt_cmd_t cmd_i,
  output wmt_sts_t sts_o,
  input  wmt_in_t  in_data_i,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output wmt_out_t out_data_o
);

  localparam int AW = $clog2(ENTRIES);
  localparam int EW = KEY_BITS + WEIGHT_BITS;
  localparam logic [AW-1:0] LAST_ADDR = AW'(ENTRIES - 1);

  wmt_in_t item_q;
  logic [AW-1:0] addr_q;
  logic [ENTRIES-1:0] vld_q;

  // Read pipeline stage: entry data is registered in the RAM and lands in the cycle after its address.
  logic chk_q, chk_vld_q;
  logic [AW-1:0] chk_idx_q;
  logic [EW-1:0] rdata;
  logic [KEY_BITS-1:0] rd_key;
  logic signed [WEIGHT_BITS-1:0] rd_w;

  // Search trackers.
  logic hit_q, free_q, best_q;
  logic [AW-1:0] hit_idx_q, free_idx_q, best_idx_q;
  logic signed [WEIGHT_BITS-1:0] hit_w_q, best_w_q;
  logic [KEY_BITS-1:0] best_key_q;

  // Write port and result.
  logic we;
  logic [AW-1:0] waddr;
  logic [EW-1:0] wdata;
  logic signed [WEIGHT_BITS:0] sum;
  logic signed [WEIGHT_BITS-1:0] sat_w;
  wmt_out_t res;
  wmt_out_t res_q;
  logic out_valid_q;
  logic better;

  assign rd_key = rdata[EW-1:WEIGHT_BITS];
  assign rd_w   = $signed(rdata[WEIGHT_BITS-1:0]);

  wmt_ram #(
    .WIDTH(EW),
    .DEPTH(ENTRIES)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .re_i   (cmd_i.read),
    .raddr_i(addr_q),
    .rdata_o(rdata)
  );

  assign sts_o.last     = (addr_q == LAST_ADDR);
  assign sts_o.out_free = !out_valid_q || !out_stall_i;

  // Item register and scan address.
  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      item_q <= in_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      addr_q <= '0;
      chk_q  <= 1'b0;
    end else begin
      chk_q <= cmd_i.read;
      if (cmd_i.start) begin
        addr_q <= '0;
      end else if (cmd_i.read && !sts_o.last) begin
        addr_q <= addr_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.read) begin
      chk_idx_q <= addr_q;
      chk_vld_q <= vld_q[addr_q];
    end
  end

  // A stored entry beats the best so far on greater weight, or equal weight and smaller key.
  assign better = !best_q || (rd_w > best_w_q) ||
                  ((rd_w == best_w_q) && (rd_key < best_key_q));

  // Trackers for key hit, first free slot and top entry.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_q  <= 1'b0;
      free_q <= 1'b0;
      best_q <= 1'b0;
    end else if (cmd_i.start) begin
      hit_q  <= 1'b0;
      free_q <= 1'b0;
      best_q <= 1'b0;
    end else if (chk_q) begin
      if (chk_vld_q) begin
        if (!hit_q && (rd_key == item_q.key)) begin
          hit_q <= 1'b1;
        end
        if (better) begin
          best_q <= 1'b1;
        end
      end else if (!free_q) begin
        free_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (chk_q) begin
      if (chk_vld_q) begin
        if (!hit_q && (rd_key == item_q.key)) begin
          hit_idx_q <= chk_idx_q;
          hit_w_q   <= rd_w;
        end
        if (better) begin
          best_idx_q <= chk_idx_q;
          best_w_q   <= rd_w;
          best_key_q <= rd_key;
        end
      end else if (!free_q) begin
        free_idx_q <= chk_idx_q;
      end
    end
  end

  // Saturating sum of the stored weight and the pushed weight.
  assign sum = {hit_w_q[WEIGHT_BITS-1], hit_w_q} +
               {item_q.weight[WEIGHT_BITS-1], item_q.weight};

  always_comb begin
    if (sum[WEIGHT_BITS] != sum[WEIGHT_BITS-1]) begin
      sat_w = sum[WEIGHT_BITS] ? {1'b1, {(WEIGHT_BITS-1){1'b0}}}
                               : {1'b0, {(WEIGHT_BITS-1){1'b1}}};
    end else begin
      sat_w = sum[WEIGHT_BITS-1:0];
    end
  end

  // Commit: table update and result for the current item.
  always_comb begin
    we    = 1'b0;
    waddr = hit_idx_q;
    wdata = {item_q.key, sat_w};
    res   = '0;
    case (item_q.kind) inside
      OP_PUSH: begin
        if (hit_q) begin
          we = cmd_i.commit;
        end else if (free_q) begin
          we    = cmd_i.commit;
          waddr = free_idx_q;
          wdata = {item_q.key, item_q.weight};
        end else begin
          res.status = ST_FULL;
        end
      end
      OP_POP, OP_TOP: begin
        if (best_q) begin
          res.result_key = best_key_q;
        end else begin
          res.status = ST_EMPTY;
        end
      end
      default: begin
        res = '0;
      end
    endcase
  end

  // Valid bits: set on a new entry, cleared by a pop.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (cmd_i.commit) begin
      if (item_q.kind == OP_PUSH && !hit_q && free_q) begin
        vld_q[free_idx_q] <= 1'b1;
      end else if (item_q.kind == OP_POP && best_q) begin
        vld_q[best_idx_q] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      res_q <= res;
    end
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_data_o <= res_q;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

>>> src/weighted_max_table.sv
`timescale 1ns / 1ps
// Channel | Direction | Handshake               | Beat
// in      | input     | in_valid_i / in_stall_o | wmt_in_t  (kind, key, weight)
// out     | output    | out_valid_o / out_stall_i | wmt_out_t (result_key, status)
//
// Each item is checked against every table entry before its result beat:
// the scan reads one table entry per cycle through the single RAM read port.
// Reset clears the valid bits at once; key and weight storage is not cleared.
// The next item is accepted while a finished result still waits on out_stall_i;
// that item then holds before its own result until the output register frees.
module weighted_max_table import wmt_pkg::*; #(
  parameter int ENTRIES = 64
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  wmt_in_t  in_data_i,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output wmt_out_t out_data_o
);

  wmt_cmd_t cmd;
  wmt_sts_t sts;

  wmt_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_stall_o(in_stall_o),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  wmt_dp #(
    .ENTRIES(ENTRIES)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  // An accepted beat makes the block busy in the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input not stalled after accepting a beat");

  // Only defined status codes leave the block.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.status == ST_OK || out_data_o.status == ST_EMPTY ||
                     out_data_o.status == ST_FULL))
    else $error("undefined status code");

  // A failed operation reports a zero key.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.status != ST_OK |-> out_data_o.result_key == '0)
    else $error("nonzero key with error status");

  // A new result beat is never raised by the same edge that accepts an input beat.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> !$past(in_valid_i && !in_stall_o))
    else $error("result beat without completed scan");

endmodule

>>> tb/wmt_answer_checker.sv
`timescale 1ns / 1ps
module wmt_answer_checker import wmt_pkg::*; #(
  parameter int SLOTS = 64
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  input  logic     in_stall_i,
  input  wmt_in_t  in_data_i,
  input  logic     out_valid_i,
  input  logic     out_stall_i,
  input  wmt_out_t out_data_i,
  output int       errors_o,
  output int       pending_o
);

  localparam longint WEIGHT_HI = (longint'(1) <<< (WEIGHT_BITS - 1)) - 1;
  localparam longint WEIGHT_LO = -WEIGHT_HI - 1;

  // Shadow copy of the table contents.
  logic [KEY_BITS-1:0]           slot_key    [SLOTS];
  logic signed [WEIGHT_BITS-1:0] slot_weight [SLOTS];
  logic                          slot_used   [SLOTS];

  // Answers owed by the block, oldest first.
  wmt_out_t owed_answers[$];
  int       mismatches;

  // Adds two weights and clamps the sum to the signed weight range.
  function automatic logic signed [WEIGHT_BITS-1:0] clamped_sum(
    input logic signed [WEIGHT_BITS-1:0] a,
    input logic signed [WEIGHT_BITS-1:0] b
  );
    longint s;
    s = longint'(a) + longint'(b);
    if (s > WEIGHT_HI) begin
      s = WEIGHT_HI;
    end else if (s < WEIGHT_LO) begin
      s = WEIGHT_LO;
    end
    return s[WEIGHT_BITS-1:0];
  endfunction

  // Index of the heaviest entry, the smallest key breaking ties; -1 when empty.
  function automatic int heaviest_slot();
    int best;
    best = -1;
    for (int i = 0; i < SLOTS; i++) begin
      if (slot_used[i]) begin
        if (best < 0 || slot_weight[i] > slot_weight[best] ||
            (slot_weight[i] == slot_weight[best] && slot_key[i] < slot_key[best])) begin
          best = i;
        end
      end
    end
    return best;
  endfunction

  // Applies one request to the shadow table and returns the answer it earns.
  function automatic wmt_out_t apply_request(input wmt_in_t req);
    wmt_out_t ans;
    int       hit;
    int       free_idx;
    int       top_idx;
    ans      = '0;
    ans.status = ST_OK;
    hit      = -1;
    free_idx = -1;
    case (req.kind)
      OP_PUSH: begin
        for (int i = 0; i < SLOTS; i++) begin
          if (slot_used[i]) begin
            if (slot_key[i] == req.key && hit < 0) hit = i;
          end else if (free_idx < 0) begin
            free_idx = i;
          end
        end
        if (hit >= 0) begin
          slot_weight[hit] = clamped_sum(slot_weight[hit], req.weight);
        end else if (free_idx >= 0) begin
          slot_key[free_idx]    = req.key;
          slot_weight[free_idx] = req.weight;
          slot_used[free_idx]   = 1'b1;
        end else begin
          ans.status = ST_FULL;
        end
      end
      OP_POP, OP_TOP: begin
        top_idx = heaviest_slot();
        if (top_idx < 0) begin
          ans.status = ST_EMPTY;
        end else begin
          ans.result_key = slot_key[top_idx];
          if (req.kind == OP_POP) slot_used[top_idx] = 1'b0;
        end
      end
      default: begin
      end
    endcase
    return ans;
  endfunction

  // Compares one result beat with the oldest owed answer.
  task automatic check_answer(input wmt_out_t got);
    wmt_out_t want;
    if (owed_answers.size() == 0) begin
      $display("%0t: unexpected result beat, expected none, got key %h status %0d",
               $time, got.result_key, got.status);
      mismatches++;
    end else begin
      want = owed_answers.pop_front();
      if (got.result_key !== want.result_key) begin
        $display("%0t: result_key mismatch, expected %h, got %h",
                 $time, want.result_key, got.result_key);
        mismatches++;
      end
      if (got.status !== want.status) begin
        $display("%0t: status mismatch, expected %0d, got %0d",
                 $time, want.status, got.status);
        mismatches++;
      end
    end
  endtask

  // Results are checked before the request of the same edge is predicted,
  // since a result always belongs to an earlier request.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < SLOTS; i++) slot_used[i] = 1'b0;
      owed_answers.delete();
      mismatches = 0;
      errors_o  <= 0;
      pending_o <= 0;
    end else begin
      if (out_valid_i && !out_stall_i) check_answer(out_data_i);
      if (in_valid_i && !in_stall_i) owed_answers.push_back(apply_request(in_data_i));
      errors_o  <= mismatches;
      pending_o <= owed_answers.size();
    end
  end

endmodule

>>> tb/tb_weighted_max_table.sv
`timescale 1ns / 1ps
module tb_weighted_max_table;
  import wmt_pkg::*;

  localparam int ENTRIES     = 64;
  localparam int PHASE_BEATS = 432;
  localparam int MODE_SPAN   = 48;
  localparam int CYCLE_LIMIT = 1000000;

  localparam logic [KIND_BITS-1:0] OP_UNUSED = 2'd3;
  localparam logic signed [WEIGHT_BITS-1:0] WEIGHT_TOP    = {1'b0, {(WEIGHT_BITS-1){1'b1}}};
  localparam logic signed [WEIGHT_BITS-1:0] WEIGHT_BOTTOM = {1'b1, {(WEIGHT_BITS-1){1'b0}}};
  localparam logic [KEY_BITS-1:0] KEY_TOP = '1;

  typedef enum {FILLING, DRAINING, CHURNING} traffic_mode_e;

  logic     clk       = 1'b0;
  logic     rst_n     = 1'b0;
  logic     in_valid  = 1'b0;
  logic     in_stall;
  wmt_in_t  in_data   = '0;
  logic     out_valid;
  logic     out_stall = 1'b0;
  wmt_out_t out_data;

  int            idle_pct  = 0;
  int            stall_pct = 0;
  int            push_pct;
  int            pop_pct;
  logic [15:0]   key_salt;
  traffic_mode_e mode;
  int            errors;
  int            pending;
  int            cycle_count;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  weighted_max_table #(
    .ENTRIES(ENTRIES)
  ) i_dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_data_o (out_data)
  );

  wmt_answer_checker #(
    .SLOTS(ENTRIES)
  ) i_checker (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_stall_i (in_stall),
    .in_data_i  (in_data),
    .out_valid_i(out_valid),
    .out_stall_i(out_stall),
    .out_data_i (out_data),
    .errors_o   (errors),
    .pending_o  (pending)
  );

  // The receiver stalls at random, at the rate of the current phase.
  always @(posedge clk) begin
    out_stall <= ($urandom_range(0, 99) < stall_pct);
  end

  function automatic wmt_in_t beat_of(input logic [KIND_BITS-1:0] kind,
                                      input logic [KEY_BITS-1:0] key,
                                      input logic signed [WEIGHT_BITS-1:0] weight);
    wmt_in_t b;
    b.kind   = kind;
    b.key    = key;
    b.weight = weight;
    return b;
  endfunction

  // Presents one beat, with a random idle gap first, and holds it until taken.
  task automatic send(input wmt_in_t b);
    if ($urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < idle_pct);
    end
    in_valid <= 1'b1;
    in_data  <= b;
    do @(posedge clk); while (in_stall);
  endtask

  // Keys mostly come from a pool a little larger than the table, so that
  // entries get hit again and the table fills up; weights favor ties and
  // the ends of the range.
  function automatic wmt_in_t random_request();
    wmt_in_t b;
    int      r;
    int      s;
    r = $urandom_range(0, 99);
    if (r < push_pct) begin
      b.kind = OP_PUSH;
    end else if (r < push_pct + pop_pct) begin
      b.kind = OP_POP;
    end else if (r < 97) begin
      b.kind = OP_TOP;
    end else begin
      b.kind = OP_UNUSED;
    end
    s = $urandom_range(0, 99);
    if (s < 8) begin
      b.key = KEY_BITS'($urandom());
    end else if (s < 12) begin
      b.key = $urandom_range(0, 1) ? KEY_TOP : '0;
    end else begin
      b.key = KEY_BITS'($urandom_range(0, 79)) ^ key_salt;
    end
    s = $urandom_range(0, 99);
    if (s < 35) begin
      b.weight = (int'($urandom_range(0, 8)) - 4) * 65536;
    end else if (s < 60) begin
      b.weight = $urandom();
    end else if (s < 75) begin
      b.weight = $urandom_range(0, 1) ? WEIGHT_TOP : WEIGHT_BOTTOM;
    end else if (s < 90) begin
      b.weight = $urandom_range(0, 1) ? WEIGHT_TOP - $urandom_range(0, 3)
                                      : WEIGHT_BOTTOM + $urandom_range(0, 3);
    end else begin
      b.weight = int'($urandom_range(0, 255)) - 128;
    end
    return b;
  endfunction

  // Stimulus: reset, a directed walk through the corner cases, then four
  // random phases with different idle and stall rates.
  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Empty table, the unused kind, saturation at both ends and tie breaks.
    send(beat_of(OP_TOP, 16'h0000, 0));
    send(beat_of(OP_POP, 16'h0000, 0));
    send(beat_of(OP_UNUSED, KEY_TOP, -1));
    send(beat_of(OP_PUSH, KEY_TOP, WEIGHT_TOP));
    send(beat_of(OP_PUSH, KEY_TOP, 1));
    send(beat_of(OP_TOP, 16'h0000, 0));
    send(beat_of(OP_PUSH, 16'h0000, WEIGHT_BOTTOM));
    send(beat_of(OP_PUSH, 16'h0000, -1));
    send(beat_of(OP_PUSH, 16'h1234, WEIGHT_TOP));
    send(beat_of(OP_TOP, KEY_TOP, WEIGHT_TOP));
    send(beat_of(OP_POP, 16'h0000, 0));
    send(beat_of(OP_POP, 16'h0000, 0));
    // Only the entry with the lowest weight is left, then a tie at that weight.
    send(beat_of(OP_TOP, 16'h0000, 0));
    send(beat_of(OP_PUSH, 16'h5555, WEIGHT_BOTTOM));
    send(beat_of(OP_POP, 16'h0000, 0));
    send(beat_of(OP_PUSH, 16'h5555, WEIGHT_BOTTOM));
    send(beat_of(OP_POP, 16'h0000, 0));
    send(beat_of(OP_POP, 16'h0000, 0));
    // Sums that cancel to zero and a tie at zero.
    send(beat_of(OP_PUSH, 16'haaaa, 32'sh0001_0000));
    send(beat_of(OP_PUSH, 16'haaaa, -32'sh0001_0000));
    send(beat_of(OP_PUSH, 16'h0001, 0));
    send(beat_of(OP_TOP, 16'hffff, 0));
    send(beat_of(OP_UNUSED, 16'h0000, 0));
    send(beat_of(OP_POP, 16'h0000, 0));
    send(beat_of(OP_POP, 16'h0000, 0));

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 84; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 84; end
        default: begin idle_pct = 35; stall_pct = 35; end
      endcase
      key_salt = 16'($urandom());
      for (int n = 0; n < PHASE_BEATS; n++) begin
        // Alternate between filling, draining and mixed traffic.
        if (n % MODE_SPAN == 0) begin
          mode = traffic_mode_e'($urandom_range(0, 2));
          case (mode)
            FILLING:  begin push_pct = 80; pop_pct = 8;  end
            DRAINING: begin push_pct = 15; pop_pct = 70; end
            default:  begin push_pct = 50; pop_pct = 25; end
          endcase
        end
        send(random_request());
      end
    end

    // Drain the remaining results, then allow the block's latency to pass.
    in_valid  <= 1'b0;
    stall_pct = 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (ENTRIES + 8) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // Watchdog on the total run length.
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Regression FAIL");
    $finish;
  end

endmodule
